### design/fdep_pkg.sv
package fdep_pkg;

    // entry geometry
    localparam int ENTRY_BYTES = 32;
    localparam int POS_W       = $clog2(ENTRY_BYTES);
    localparam int NAME_BYTES  = 11;
    localparam int BASE_BYTES  = 8;
    localparam int NIDX_W      = $clog2(NAME_BYTES);
    localparam int NLEN_W      = $clog2(NAME_BYTES + 2);
    localparam int BLEN_W      = $clog2(BASE_BYTES + 1);
    localparam int DEPTH_W     = 6;

    // byte offsets inside an entry
    localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_EXT      = POS_W'(8);
    localparam logic [POS_W-1:0] POS_ATTR     = POS_W'(11);
    localparam logic [POS_W-1:0] POS_CLUS_H0  = POS_W'(20);
    localparam logic [POS_W-1:0] POS_CLUS_H1  = POS_W'(21);
    localparam logic [POS_W-1:0] POS_CLUS_L0  = POS_W'(26);
    localparam logic [POS_W-1:0] POS_CLUS_L1  = POS_W'(27);
    localparam logic [POS_W-1:0] POS_SIZE0    = POS_W'(28);
    localparam logic [POS_W-1:0] POS_SIZE1    = POS_W'(29);
    localparam logic [POS_W-1:0] POS_SIZE2    = POS_W'(30);
    localparam logic [POS_W-1:0] POS_SIZE3    = POS_W'(31);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(ENTRY_BYTES - 1);

    // byte codes
    localparam logic [7:0] BYTE_END     = 8'h00;
    localparam logic [7:0] BYTE_DELETED = 8'hE5;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_DOT     = 8'h2E;

    // attribute bits
    localparam logic [3:0] ATTR_LFN_MASK = 4'hF;
    localparam int         ATTR_VOL_BIT  = 3;
    localparam int         ATTR_DIR_BIT  = 4;

    // result kinds
    localparam logic KIND_NAME = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       dir_start;
    } fdep_in_t;

    typedef struct packed {
        logic [7:0]         name_char;
        logic               entry_kind;
        logic               is_dir;
        logic [31:0]        file_size;
        logic [31:0]        start_clus;
        logic [DEPTH_W-1:0] depth;
        logic               last;
    } fdep_out_t;

    // events raised by the byte scanner
    typedef struct packed {
        logic entry_done;
        logic dir_end;
    } fdep_ev_t;

    // summary of the captured entry
    typedef struct packed {
        logic              skip;
        logic [NLEN_W-1:0] name_len;
        logic [BLEN_W-1:0] base_len;
        logic              is_dir;
        logic [31:0]       file_size;
        logic [31:0]       start_clus;
    } fdep_info_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } fdep_state_t;

endpackage

### design/fat32_directory_entry_parser_top.sv
// FAT directory entry parser, 8.3 names.
// s_ channel: one directory byte per beat; dir_start marks the first byte of a
// new directory and drops any partial entry. m_ channel: one name character
// per beat, the last beat of a run carries is_dir, file_size and start_clus.
// An entry starting with a zero byte ends the directory: one end beat
// (entry_kind 1, last 1) goes out and later bytes are dropped until dir_start.
// cfg channel: writes the 6-bit depth tag copied into every result; always ready.
// Sequence: bytes 0 to 30 of an entry are captured as they arrive. After byte
// 31 the sequencer runs the visibility check and then emits one beat per
// name character (1 to 12), during which s_ready is low; a skipped entry goes
// back to idle after the check. The end beat is loaded by the emit state.
// One character is formed per cycle while the output register is free, by a
// shared index/compare path reading the captured name bytes.
// A stalled receiver holds the output register; the sequencer waits on it and
// bytes are still taken while the last result of a run waits.
// Reset (aresetn low, synchronous) clears position, end flag, sequencer,
// output valid and the depth tag.
module fat32_directory_entry_parser_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fdep_pkg::fdep_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fdep_pkg::fdep_out_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fdep_pkg::DEPTH_W-1:0]  cfg_data
);
    import fdep_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic               accept;
    logic               busy;
    fdep_ev_t           ev;
    fdep_info_t         info;
    logic [NIDX_W-1:0]  rd_idx;
    logic [7:0]         rd_char;

    // depth tag register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            depth_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;

    fdep_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .rd_idx  (rd_idx),
        .rd_char (rd_char),
        .ev      (ev),
        .info    (info)
    );

    fdep_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ev        (ev),
        .info      (info),
        .rd_char   (rd_char),
        .depth_tag (depth_reg),
        .rd_idx    (rd_idx),
        .busy      (busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // end beat is a single zero character with no entry fields
    a_end_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.entry_kind == KIND_END) |->
            m_data.last && (m_data.name_char == BYTE_END)
            && (m_data.file_size == '0) && (m_data.start_clus == '0) && !m_data.is_dir)
        else $error("end beat carries entry data");

    // entry fields only on the last beat of a run
    a_mid_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |->
            (m_data.file_size == '0) && (m_data.start_clus == '0) && !m_data.is_dir)
        else $error("entry fields on a non-final beat");

    // input is held off while an entry or end result is being produced
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ev.dir_end || ev.entry_done |=> !s_ready)
        else $error("input taken during result sequence");

    // the two events never coincide
    a_ev_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ev.dir_end && ev.entry_done))
        else $error("end and entry completion together");

endmodule

### design/fdep_scan.sv
module fdep_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  fdep_pkg::fdep_in_t            in_data,
    input  logic [fdep_pkg::NIDX_W-1:0]   rd_idx,
    output logic [7:0]                    rd_char,
    output fdep_pkg::fdep_ev_t            ev,
    output fdep_pkg::fdep_info_t          info
);
    import fdep_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ended_reg, ended_next;
    logic [POS_W-1:0]  pos_eff;
    logic              take;
    logic              is_space;
    logic [7:0]        name_reg [0:NAME_BYTES-1];
    logic [BLEN_W-1:0] base_len_reg;
    logic              base_stop_reg;
    logic [1:0]        ext_len_reg;
    logic              ext_stop_reg;
    logic              ext_any_reg;
    logic              deleted_reg;
    logic [7:0]        attr_reg;
    logic [31:0]       size_reg;
    logic [31:0]       clus_reg;
    logic [NLEN_W-1:0] name_len;
    logic [7:0]        c0, c1;
    logic              is_dot;

    // position of this byte and whether it counts
    assign pos_eff  = in_data.dir_start ? POS_FIRST : pos_reg;
    assign take     = accept && (in_data.dir_start || !ended_reg);
    assign is_space = (in_data.data_byte == BYTE_SPACE);

    assign ev.dir_end    = take && (pos_eff == POS_FIRST) && (in_data.data_byte == BYTE_END);
    assign ev.entry_done = take && (pos_eff == POS_LAST);

    // position and end flag
    always_comb begin
        pos_next   = pos_reg;
        ended_next = ended_reg;
        if (accept && in_data.dir_start) begin
            pos_next   = POS_FIRST;
            ended_next = 1'b0;
        end
        if (take) begin
            if (ev.dir_end) begin
                pos_next   = POS_FIRST;
                ended_next = 1'b1;
            end else begin
                pos_next = pos_eff + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            ended_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
        end
    end

    // capture of name bytes, space scan and fixed fields
    always_ff @(posedge aclk) begin
        if (take) begin
            if (pos_eff < POS_W'(NAME_BYTES)) begin
                name_reg[pos_eff[NIDX_W-1:0]] <= in_data.data_byte;
            end
            if (pos_eff == POS_FIRST) begin
                base_len_reg  <= is_space ? '0 : BLEN_W'(1);
                base_stop_reg <= is_space;
                deleted_reg   <= (in_data.data_byte == BYTE_DELETED);
            end else if (pos_eff < POS_EXT) begin
                if (!base_stop_reg && !is_space) begin
                    base_len_reg <= base_len_reg + BLEN_W'(1);
                end
                if (is_space) begin
                    base_stop_reg <= 1'b1;
                end
            end else if (pos_eff == POS_EXT) begin
                ext_len_reg  <= is_space ? 2'd0 : 2'd1;
                ext_stop_reg <= is_space;
                ext_any_reg  <= !is_space;
            end else if (pos_eff < POS_ATTR) begin
                if (!ext_stop_reg && !is_space) begin
                    ext_len_reg <= ext_len_reg + 2'd1;
                end
                if (is_space) begin
                    ext_stop_reg <= 1'b1;
                end
                if (!is_space) begin
                    ext_any_reg <= 1'b1;
                end
            end
            case (pos_eff)
                POS_ATTR:    attr_reg        <= in_data.data_byte;
                POS_CLUS_H0: clus_reg[23:16] <= in_data.data_byte;
                POS_CLUS_H1: clus_reg[31:24] <= in_data.data_byte;
                POS_CLUS_L0: clus_reg[7:0]   <= in_data.data_byte;
                POS_CLUS_L1: clus_reg[15:8]  <= in_data.data_byte;
                POS_SIZE0:   size_reg[7:0]   <= in_data.data_byte;
                POS_SIZE1:   size_reg[15:8]  <= in_data.data_byte;
                POS_SIZE2:   size_reg[23:16] <= in_data.data_byte;
                POS_SIZE3:   size_reg[31:24] <= in_data.data_byte;
                default: ;
            endcase
        end
    end

    // formatted name length and dot entry check
    always_comb begin
        name_len = NLEN_W'(base_len_reg);
        if (ext_any_reg) begin
            name_len = NLEN_W'(base_len_reg) + NLEN_W'(ext_len_reg) + NLEN_W'(1);
        end
        c0 = (base_len_reg != '0) ? name_reg[0] : BYTE_DOT;
        if (base_len_reg >= BLEN_W'(2)) begin
            c1 = name_reg[1];
        end else if (base_len_reg == BLEN_W'(1)) begin
            c1 = BYTE_DOT;
        end else begin
            c1 = name_reg[BASE_BYTES];
        end
        is_dot = (c0 == BYTE_DOT)
              && ((name_len == NLEN_W'(1))
               || ((name_len == NLEN_W'(2)) && (c1 == BYTE_DOT)));
    end

    assign info.skip = deleted_reg
                    || ((attr_reg[3:0] & ATTR_LFN_MASK) == ATTR_LFN_MASK)
                    || attr_reg[ATTR_VOL_BIT]
                    || is_dot;
    assign info.name_len   = name_len;
    assign info.base_len   = base_len_reg;
    assign info.is_dir     = attr_reg[ATTR_DIR_BIT];
    assign info.file_size  = size_reg;
    assign info.start_clus = clus_reg;

    assign rd_char = name_reg[rd_idx];

endmodule

### design/fdep_seq.sv
module fdep_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fdep_pkg::fdep_ev_t             ev,
    input  fdep_pkg::fdep_info_t           info,
    input  logic [7:0]                     rd_char,
    input  logic [fdep_pkg::DEPTH_W-1:0]   depth_tag,
    output logic [fdep_pkg::NIDX_W-1:0]    rd_idx,
    output logic                           busy,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fdep_pkg::fdep_out_t            m_data
);
    import fdep_pkg::*;

    fdep_state_t       state_reg, state_next;
    logic [NLEN_W-1:0] cnt_reg, cnt_next;
    logic              end_reg, end_next;
    logic              m_valid_reg, m_valid_next;
    fdep_out_t         m_data_reg, m_data_next;
    logic              out_free;
    logic              item_last;
    logic [7:0]        item_char;

    assign out_free = !m_valid_reg || m_ready;

    // name byte index: base part directly, extension part shifted past the dot
    always_comb begin
        if (cnt_reg < NLEN_W'(info.base_len)) begin
            rd_idx = NIDX_W'(cnt_reg);
        end else begin
            rd_idx = NIDX_W'(cnt_reg + NLEN_W'(BASE_BYTES - 1) - NLEN_W'(info.base_len));
        end
    end

    // current item
    always_comb begin
        item_last = end_reg || (info.name_len == '0)
                 || (cnt_reg == info.name_len - NLEN_W'(1));
        if (end_reg || (info.name_len == '0)) begin
            item_char = BYTE_END;
        end else if (cnt_reg == NLEN_W'(info.base_len)) begin
            item_char = BYTE_DOT;
        end else begin
            item_char = rd_char;
        end
    end

    // sequencer and output register
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        end_next     = end_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (ev.dir_end) begin
                    end_next   = 1'b1;
                    state_next = ST_EMIT;
                end else if (ev.entry_done) begin
                    end_next   = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = info.skip ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.name_char  = item_char;
                    m_data_next.entry_kind = end_reg ? KIND_END : KIND_NAME;
                    m_data_next.depth      = depth_tag;
                    m_data_next.last       = item_last;
                    m_data_next.is_dir     = 1'b0;
                    m_data_next.file_size  = '0;
                    m_data_next.start_clus = '0;
                    if (item_last && !end_reg) begin
                        m_data_next.is_dir     = info.is_dir;
                        m_data_next.file_size  = info.file_size;
                        m_data_next.start_clus = info.start_clus;
                    end
                    cnt_next = cnt_reg + NLEN_W'(1);
                    if (item_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
